// ===== sv/multi_channel_key_debouncer_macros.svh =====
// assertion macros shared by the debouncer checker
`ifndef MULTI_CHANNEL_KEY_DEBOUNCER_MACROS_SVH
`define MULTI_CHANNEL_KEY_DEBOUNCER_MACROS_SVH

// checked only while out of reset
`define MCKD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define MCKD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/mckd_pkg.sv =====
// shared constants and types of the key debouncer
package mckd_pkg;

  localparam int NUM_CHANNELS = 11;
  localparam int ChIdxW       = 4;
  localparam int PressW       = 9;
  localparam int RelW         = 5;
  localparam int QualW        = 8;
  localparam int SlowCntW     = 4;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 9;
  localparam int InDataW      = 16;
  localparam int OutDataW     = 40;

  localparam logic [RelW-1:0] FastRelHold = 5'd30;

  localparam logic [CfgIdxW-1:0] RegPressQualify = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStuckLimit   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegReleaseSlow  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegReleaseFast  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSlowCount    = 3'd4;

  localparam logic [QualW-1:0]    PressQualifyRst = 8'd3;
  localparam logic [PressW-1:0]   StuckLimitRst   = 9'd400;
  localparam logic [RelW-1:0]     ReleaseSlowRst  = 5'd30;
  localparam logic [RelW-1:0]     ReleaseFastRst  = 5'd1;
  localparam logic [SlowCntW-1:0] SlowCountRst    = 4'd5;

  typedef struct packed {
    logic [QualW-1:0]    press_qualify;
    logic [PressW-1:0]   stuck_limit;
    logic [RelW-1:0]     release_slow;
    logic [RelW-1:0]     release_fast;
    logic [SlowCntW-1:0] slow_count;
  } cfg_t;

  typedef struct packed {
    logic step;
    logic tick;
    logic released;
    logic slow;
    logic rd_clr;
  } chan_ctl_t;

  typedef struct packed {
    logic status;
    logic error;
    logic pend;
    logic pend_cur;
  } chan_st_t;

endpackage

// ===== sv/mckd_cfg_regs.sv =====
// configuration register file of the key debouncer
module mckd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mckd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mckd_pkg::CfgDataW-1:0] cfg_wdata_i,
  output mckd_pkg::cfg_t                cfg_o
);

  mckd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        mckd_pkg::RegPressQualify: cfg_d.press_qualify = cfg_wdata_i[mckd_pkg::QualW-1:0];
        mckd_pkg::RegStuckLimit:   cfg_d.stuck_limit   = cfg_wdata_i[mckd_pkg::PressW-1:0];
        mckd_pkg::RegReleaseSlow:  cfg_d.release_slow  = cfg_wdata_i[mckd_pkg::RelW-1:0];
        mckd_pkg::RegReleaseFast:  cfg_d.release_fast  = cfg_wdata_i[mckd_pkg::RelW-1:0];
        mckd_pkg::RegSlowCount:    cfg_d.slow_count    = cfg_wdata_i[mckd_pkg::SlowCntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_qualify <= mckd_pkg::PressQualifyRst;
      cfg_q.stuck_limit   <= mckd_pkg::StuckLimitRst;
      cfg_q.release_slow  <= mckd_pkg::ReleaseSlowRst;
      cfg_q.release_fast  <= mckd_pkg::ReleaseFastRst;
      cfg_q.slow_count    <= mckd_pkg::SlowCountRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/mckd_channel.sv =====
// one debounce channel: press and release counters, status, error and event bits
module mckd_channel (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mckd_pkg::cfg_t      cfg_i,
  input  mckd_pkg::chan_ctl_t ctl_i,
  output mckd_pkg::chan_st_t  st_o
);

  logic [mckd_pkg::PressW-1:0] pc_q, pc_d, pc_inc;
  logic [mckd_pkg::RelW-1:0]   rc_q, rc_d, rc_inc, rel_thr;
  logic                        status_q, status_d;
  logic                        error_q, error_d;
  logic                        pend_q, pend_d;
  logic                        stuck;

  always_comb begin
    pc_d     = pc_q;
    rc_d     = rc_q;
    status_d = status_q;
    error_d  = error_q;
    pend_d   = pend_q;
    stuck    = 1'b0;
    pc_inc   = (&pc_q) ? pc_q : pc_q + 1'b1;
    rc_inc   = (&rc_q) ? rc_q : rc_q + 1'b1;
    rel_thr  = ctl_i.slow ? cfg_i.release_slow : cfg_i.release_fast;
    if (ctl_i.tick) begin
      if (ctl_i.released) begin
        pc_d = '0;
        rc_d = rc_inc;
        if (rc_inc > rel_thr) begin
          rc_d = ctl_i.slow ? cfg_i.release_slow : mckd_pkg::FastRelHold;
          if (status_q) begin
            status_d = 1'b0;
            error_d  = 1'b0;
          end
        end
      end else begin
        rc_d = '0;
        pc_d = pc_inc;
        if (pc_inc > cfg_i.stuck_limit) begin
          pc_d    = cfg_i.stuck_limit;
          error_d = 1'b1;
          stuck   = 1'b1;
        end
        // fast channels qualify on every pressed tick
        if (!ctl_i.slow || (!stuck && (pc_inc > {1'b0, cfg_i.press_qualify}))) begin
          status_d = 1'b1;
          pend_d   = pend_q | ~status_q;
        end
      end
    end else if (ctl_i.rd_clr) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      rc_q     <= '0;
      status_q <= 1'b0;
      error_q  <= 1'b0;
      pend_q   <= 1'b0;
    end else if (ctl_i.step) begin
      pc_q     <= pc_d;
      rc_q     <= rc_d;
      status_q <= status_d;
      error_q  <= error_d;
      pend_q   <= pend_d;
    end
  end

  assign st_o.status   = status_d;
  assign st_o.error    = error_d;
  assign st_o.pend     = pend_d;
  assign st_o.pend_cur = pend_q;

endmodule

// ===== sv/multi_channel_key_debouncer.sv =====
// top level of the multi-channel key debouncer
//
// input stream: one word per sample tick or event read. tuser selects the
// kind (0 tick, 1 read and clear one key event). tdata carries the raw key
// levels (high means released) and the channel index of a read.
// output stream: one word per input word, with the read channel's event bit
// before clearing and the status, error and pending event vectors after it.
// configuration: write enable, register index and data, written while idle.
// pipeline: an accepted word sits in the input register; its result is loaded
// into the result register once that is free or moving, and leaves from there.
// one word per cycle is taken in steady state while the receiver does not
// stall; all eleven channels update in parallel in the single logic stage
// between the two registers.
// reset clears all counters and flags, loads the register defaults and
// empties both pipeline registers.
// when the receiver stalls the result register holds; the input register
// still takes one more word, after which tready drops until the output moves.
module multi_channel_key_debouncer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mckd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mckd_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // raw_levels [10:0], key_index [14:11], zero [15]
  input  logic [mckd_pkg::InDataW-1:0]  s_axis_tdata_i,
  // req_type [0]
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // key_event [0], status_bits [11:1], error_bits [22:12], event_bits [33:23],
  // zero [39:34]
  output logic [mckd_pkg::OutDataW-1:0] m_axis_tdata_o
);

  localparam int N = mckd_pkg::NUM_CHANNELS;

  mckd_pkg::cfg_t cfg;

  logic                          in_valid_q;
  logic                          in_req_q;
  logic [N-1:0]                  in_levels_q;
  logic [mckd_pkg::ChIdxW-1:0]   in_idx_q;
  logic                          out_valid_q, out_valid_d;
  logic [mckd_pkg::OutDataW-1:0] out_data_q, out_data_d;
  logic                          out_ready;
  logic                          advance;
  logic                          s_accept;

  logic [N-1:0] status_v, error_v, pend_v, pend_cur_v, rd_sel_v;

  assign out_ready       = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_ready;
  assign s_axis_tready_o = !in_valid_q || out_ready;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  mckd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  for (genvar i = 0; i < N; i++) begin : g_ch
    mckd_pkg::chan_ctl_t ctl;
    mckd_pkg::chan_st_t  st;

    assign rd_sel_v[i]  = in_req_q && (in_idx_q == mckd_pkg::ChIdxW'(i));
    assign ctl.step     = advance;
    assign ctl.tick     = !in_req_q;
    assign ctl.released = in_levels_q[i];
    assign ctl.slow     = mckd_pkg::ChIdxW'(i) < cfg.slow_count;
    assign ctl.rd_clr   = rd_sel_v[i];

    mckd_channel u_ch (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cfg_i  (cfg),
      .ctl_i  (ctl),
      .st_o   (st)
    );

    assign status_v[i]   = st.status;
    assign error_v[i]    = st.error;
    assign pend_v[i]     = st.pend;
    assign pend_cur_v[i] = st.pend_cur;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_ready) begin
      out_valid_d = in_valid_q;
    end
    if (advance) begin
      // indices beyond the channels match no select bit and read zero
      out_data_d = {(mckd_pkg::OutDataW - 3 * N - 1)'(0), pend_v, error_v, status_v,
                    |(pend_cur_v & rd_sel_v)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_req_q    <= s_axis_tuser_i;
      in_levels_q <= s_axis_tdata_i[N-1:0];
      in_idx_q    <= s_axis_tdata_i[N +: mckd_pkg::ChIdxW];
    end
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== sv/mckd_checker.sv =====
// port-level checks of the key debouncer and their binding
`include "multi_channel_key_debouncer_macros.svh"

module mckd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [mckd_pkg::OutDataW-1:0] m_axis_tdata_o
);

  `MCKD_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !m_axis_tvalid_o, "output valid in reset")

  `MCKD_ASSERT(a_stall_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled output word changed")

  `MCKD_ASSERT(a_ready_when_empty, !m_axis_tvalid_o |-> s_axis_tready_o, "input stalled with empty output")

  `MCKD_ASSERT(a_out_follows_in, $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o, 2), "output word without input word")

endmodule

bind multi_channel_key_debouncer mckd_checker u_mckd_checker (.*);

// ===== test/testbench.sv =====
// self-checking testbench for the multi-channel key debouncer
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic                              req;
    logic [mckd_pkg::NUM_CHANNELS-1:0] levels;
    logic [mckd_pkg::ChIdxW-1:0]       idx;
  } key_word_t;

  typedef struct packed {
    logic [5:0]                        pad;
    logic [mckd_pkg::NUM_CHANNELS-1:0] events;
    logic [mckd_pkg::NUM_CHANNELS-1:0] errors;
    logic [mckd_pkg::NUM_CHANNELS-1:0] status;
    logic                              key_event;
  } key_report_t;

  localparam int IdlePct  = 10;
  localparam int HoldLen  = 80;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [mckd_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [mckd_pkg::CfgDataW-1:0] cfg_wdata = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [mckd_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                          s_axis_tuser = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [mckd_pkg::OutDataW-1:0] m_axis_tdata;

  multi_channel_key_debouncer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // debouncer state as the block should hold it
  logic [mckd_pkg::PressW-1:0]       press_cnt [mckd_pkg::NUM_CHANNELS];
  logic [mckd_pkg::RelW-1:0]         rel_cnt   [mckd_pkg::NUM_CHANNELS];
  logic [mckd_pkg::NUM_CHANNELS-1:0] key_status = '0;
  logic [mckd_pkg::NUM_CHANNELS-1:0] key_errors = '0;
  logic [mckd_pkg::NUM_CHANNELS-1:0] key_events = '0;

  logic [mckd_pkg::QualW-1:0]    qual_thr  = mckd_pkg::PressQualifyRst;
  logic [mckd_pkg::PressW-1:0]   stuck_thr = mckd_pkg::StuckLimitRst;
  logic [mckd_pkg::RelW-1:0]     rel_slow  = mckd_pkg::ReleaseSlowRst;
  logic [mckd_pkg::RelW-1:0]     rel_fast  = mckd_pkg::ReleaseFastRst;
  logic [mckd_pkg::SlowCntW-1:0] slow_n    = mckd_pkg::SlowCountRst;

  key_word_t   key_word_q [$];
  key_report_t report_q [$];
  int          mismatch_cnt = 0;
  bit          calm = 1'b0;
  bit          hold_tgl = 1'b0;

  // random key level generator state
  logic [mckd_pkg::NUM_CHANNELS-1:0] gen_lvl = '1;
  int                                gen_run [mckd_pkg::NUM_CHANNELS];

  initial begin
    for (int ch = 0; ch < mckd_pkg::NUM_CHANNELS; ch++) begin
      press_cnt[ch] = '0;
      rel_cnt[ch]   = '0;
      gen_run[ch]   = 0;
    end
  end

  function automatic key_report_t advance_keys(key_word_t w);
    key_report_t               r;
    logic                      slow;
    logic                      stuck;
    logic [mckd_pkg::RelW-1:0] thr;
    r = '0;
    if (!w.req) begin
      for (int ch = 0; ch < mckd_pkg::NUM_CHANNELS; ch++) begin
        slow = (ch < slow_n);
        if (w.levels[ch]) begin
          press_cnt[ch] = '0;
          if (rel_cnt[ch] != '1) rel_cnt[ch] = rel_cnt[ch] + 1'b1;
          thr = slow ? rel_slow : rel_fast;
          if (rel_cnt[ch] > thr) begin
            rel_cnt[ch] = slow ? rel_slow : mckd_pkg::FastRelHold;
            if (key_status[ch]) begin
              key_status[ch] = 1'b0;
              key_errors[ch] = 1'b0;
            end
          end
        end else begin
          stuck = 1'b0;
          rel_cnt[ch] = '0;
          if (press_cnt[ch] != '1) press_cnt[ch] = press_cnt[ch] + 1'b1;
          if (press_cnt[ch] > stuck_thr) begin
            press_cnt[ch]  = stuck_thr;
            key_errors[ch] = 1'b1;
            stuck = 1'b1;
          end
          // fast channels qualify on every pressed tick, stuck or not
          if (!slow || (!stuck && press_cnt[ch] > qual_thr)) begin
            if (!key_status[ch]) begin
              key_status[ch] = 1'b1;
              key_events[ch] = 1'b1;
            end
          end
        end
      end
    end else if (w.idx < mckd_pkg::NUM_CHANNELS) begin
      r.key_event = key_events[w.idx];
      key_events[w.idx] = 1'b0;
    end
    r.status = key_status;
    r.errors = key_errors;
    r.events = key_events;
    return r;
  endfunction

  // sender
  key_word_t held_word;

  always @(posedge clk_i) begin : drv_proc
    if (s_axis_tvalid && s_axis_tready) report_q.push_back(advance_keys(held_word));
    if (!s_axis_tvalid || s_axis_tready) begin
      if (key_word_q.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        held_word = key_word_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, held_word.idx, held_word.levels};
        s_axis_tuser  <= held_word.req;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  task automatic note_mismatch(string what, logic [mckd_pkg::NUM_CHANNELS-1:0] want,
                               logic [mckd_pkg::NUM_CHANNELS-1:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch %s at %0t: expected %03h got %03h", what, $time, want, got);
  endtask

  // receiver
  bit hold_seen = 1'b0;
  int hold_left = 0;

  always @(posedge clk_i) begin : mon_proc
    key_report_t want;
    key_report_t got;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (report_q.size() == 0) begin
        note_mismatch("word with nothing pending, status", '0, got.status);
      end else begin
        want = report_q.pop_front();
        if (got.key_event !== want.key_event)
          note_mismatch("key_event", want.key_event, got.key_event);
        if (got.status !== want.status) note_mismatch("status_bits", want.status, got.status);
        if (got.errors !== want.errors) note_mismatch("error_bits", want.errors, got.errors);
        if (got.events !== want.events) note_mismatch("event_bits", want.events, got.events);
      end
    end
    if (hold_tgl != hold_seen) begin
      hold_seen = hold_tgl;
      hold_left = HoldLen;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  task automatic write_reg(logic [mckd_pkg::CfgIdxW-1:0] idx,
                           logic [mckd_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      mckd_pkg::RegPressQualify: qual_thr  = val[mckd_pkg::QualW-1:0];
      mckd_pkg::RegStuckLimit:   stuck_thr = val[mckd_pkg::PressW-1:0];
      mckd_pkg::RegReleaseSlow:  rel_slow  = val[mckd_pkg::RelW-1:0];
      mckd_pkg::RegReleaseFast:  rel_fast  = val[mckd_pkg::RelW-1:0];
      mckd_pkg::RegSlowCount:    slow_n    = val[mckd_pkg::SlowCntW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int q, int s, int rs, int rf, int n);
    write_reg(mckd_pkg::RegPressQualify, mckd_pkg::CfgDataW'(q));
    write_reg(mckd_pkg::RegStuckLimit, mckd_pkg::CfgDataW'(s));
    write_reg(mckd_pkg::RegReleaseSlow, mckd_pkg::CfgDataW'(rs));
    write_reg(mckd_pkg::RegReleaseFast, mckd_pkg::CfgDataW'(rf));
    write_reg(mckd_pkg::RegSlowCount, mckd_pkg::CfgDataW'(n));
  endtask

  task automatic push_tick(logic [mckd_pkg::NUM_CHANNELS-1:0] lv);
    key_word_t w;
    w.req    = 1'b0;
    w.levels = lv;
    w.idx    = mckd_pkg::ChIdxW'($urandom);
    key_word_q.push_back(w);
  endtask

  task automatic push_read(logic [mckd_pkg::ChIdxW-1:0] k);
    key_word_t w;
    w.req    = 1'b1;
    w.levels = mckd_pkg::NUM_CHANNELS'($urandom);
    w.idx    = k;
    key_word_q.push_back(w);
  endtask

  // held key levels with bounce; long runs let counters reach their thresholds
  task automatic queue_key_activity(int n, int max_run, int read_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < read_pct) begin
        push_read(mckd_pkg::ChIdxW'(($urandom_range(9) == 0) ? $urandom_range(15)
                                                              : $urandom_range(10)));
      end else begin
        for (int ch = 0; ch < mckd_pkg::NUM_CHANNELS; ch++) begin
          if (gen_run[ch] == 0) begin
            gen_lvl[ch] = ~gen_lvl[ch];
            gen_run[ch] = ($urandom_range(3) == 0) ? $urandom_range(1, 2)
                                                   : $urandom_range(1, max_run);
          end
          gen_run[ch]--;
        end
        push_tick(gen_lvl);
      end
    end
  endtask

  task automatic wait_all_reported();
    while (key_word_q.size() != 0 || s_axis_tvalid || report_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: register defaults after reset
    push_tick('1);
    push_tick('0);
    push_read(4'd7);
    push_read(4'd7);
    push_read(4'd15);
    push_read(4'd11);
    push_tick('0);
    push_tick('0);
    push_tick('0);
    push_read(4'd0);
    push_tick('1);
    push_tick('1);
    push_tick(11'h555);
    push_tick(11'h2aa);
    push_read(4'd10);
    push_read(4'd4);
    push_tick(11'h400);
    push_tick(11'h001);
    push_read(4'd5);
    wait_all_reported();

    // long receiver hold while the sender keeps offering
    hold_tgl = ~hold_tgl;
    queue_key_activity(260, 450, 12);
    wait_all_reported();

    // all channels fast, lowest thresholds
    set_config(0, 1, 0, 0, 0);
    queue_key_activity(200, 20, 15);
    wait_all_reported();

    // all channels slow, highest thresholds
    set_config(255, 511, 30, 30, 11);
    queue_key_activity(300, 400, 8);
    wait_all_reported();

    // out-of-range values, no idling on either side
    calm = 1'b1;
    set_config(0, 0, 31, 31, 15);
    queue_key_activity(200, 10, 15);
    wait_all_reported();
    calm = 1'b0;

    for (int p = 0; p < 4; p++) begin
      set_config($urandom_range(0, 12), $urandom_range(0, 40), $urandom_range(0, 31),
                 $urandom_range(0, 31), $urandom_range(0, 15));
      if (p == 0) begin
        queue_key_activity(125, 60, 15);
        wait_all_reported();
        queue_key_activity(125, 60, 15);
      end else begin
        queue_key_activity(250, 60, 15);
      end
      wait_all_reported();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && report_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/mckd_pkg.sv
sv/mckd_cfg_regs.sv
sv/mckd_channel.sv
sv/multi_channel_key_debouncer.sv
sv/mckd_checker.sv
test/testbench.sv
